// ===== sv/lzss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decoder package
// Default window and length sizes, the literal token size and the sequencer
// states used by the decoder module.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int WIN_BITS_DEF    = 8;
    localparam int LENGTH_BITS_DEF = 4;

    // A literal token is the flag bit followed by eight data bits.
    localparam int LIT_BITS = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_COPY
    } state_t;

endpackage

// ===== sv/lzss_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS compressed input channel
// Valid/ready channel that carries one compressed byte and the stream start
// mark per item.
// ----------------------------------------------------------------------------
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// ===== sv/lzss_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressed output channel
// Valid/ready channel that carries one decompressed byte and its last flag
// per item.
// ----------------------------------------------------------------------------
interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== sv/lzss_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS stream decoder
// Reads compressed bytes as an MSB-first bitstream, decodes literal and
// match tokens and writes every produced byte to the history window.
// ----------------------------------------------------------------------------
//  channel      dir  payload                 handshake
//  comp         in   data_byte, start_req    valid / ready
//  decomp       out  out_byte, last          valid / ready
//  cfg_wr_*     in   output_length (32 b)    write enable, no wait
//
//  A compressed item is accepted in ST_IDLE; its bits then pass through the
//  shared bit shifter at one bit per cycle, pausing while a literal waits on
//  a stalled output. A completed match reads the window through a registered
//  read port and copies one byte per cycle while the output is free. Once the
//  stream is finished, the trailing bits of an item are dropped. After reset
//  the block is ready at once; the window is not swept, a fill count makes
//  never-written entries read as zero. A stalled output holds the decoder in
//  place; a new item is taken only when the previous is fully decoded.
// ----------------------------------------------------------------------------
module lzss_decoder
    import lzss_pkg::*;
#(
    parameter int WIN_BITS    = WIN_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    lzss_in_if.sink      comp,
    lzss_out_if.source   decomp
);

    localparam int WIN_SIZE   = 1 << WIN_BITS;
    localparam int TOKEN_BITS = 1 + WIN_BITS + LENGTH_BITS;
    localparam int MATCH_MIN  = (TOKEN_BITS + 7) / 8;
    localparam int MAX_RUN    = (1 << LENGTH_BITS) + MATCH_MIN - 1;
    localparam int START_PTR  = WIN_SIZE - MAX_RUN;
    localparam int CNT_W      = $clog2(TOKEN_BITS + 1);
    localparam int LEFT_W     = $clog2(MAX_RUN + 1);

    localparam logic [WIN_BITS-1:0] START_PTR_W = WIN_BITS'(START_PTR);
    localparam logic [WIN_BITS:0]   FILL_FULL   = (WIN_BITS + 1)'(WIN_SIZE);

    logic [7:0] mem [WIN_SIZE];
    logic [7:0] rd_q_reg;

    state_t                  state_reg, state_next;
    logic [7:0]              byte_reg, byte_next;
    logic [2:0]              bit_idx_reg, bit_idx_next;
    logic                    bits_left_reg, bits_left_next;
    logic [TOKEN_BITS-1:0]   pend_reg, pend_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [WIN_BITS-1:0]     wptr_reg, wptr_next;
    logic [WIN_BITS:0]       fill_reg, fill_next;
    logic [31:0]             bytes_reg, bytes_next;
    logic [31:0]             olen_reg, olen_next;
    logic [WIN_BITS-1:0]     cp_addr_reg, cp_addr_next;
    logic [LEFT_W-1:0]       cp_left_reg, cp_left_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    byp_reg, byp_next;
    logic [7:0]              byp_data_reg, byp_data_next;
    logic                    hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;

    logic                    we;
    logic [7:0]              wd;
    logic                    issue;
    logic                    emit;
    logic                    out_free;
    logic                    finished;
    logic                    lit;
    logic                    tok;
    logic [TOKEN_BITS-1:0]   nb;
    logic [CNT_W-1:0]        cnt_inc;
    logic [7:0]              copy_byte;
    logic [WIN_BITS-1:0]     rel_addr;

    assign comp.ready      = (state_reg == ST_IDLE);
    assign decomp.valid    = out_valid_reg;
    assign decomp.out_byte = out_byte_reg;
    assign decomp.last     = out_last_reg;

    assign out_free  = !out_valid_reg || decomp.ready;
    assign finished  = (bytes_reg >= olen_reg);
    assign nb        = {pend_reg[TOKEN_BITS-2:0], byte_reg[bit_idx_reg]};
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign lit       = (cnt_inc == CNT_W'(LIT_BITS)) && nb[LIT_BITS-1];
    assign tok       = (cnt_inc == CNT_W'(TOKEN_BITS));
    // Entries that the current stream has not yet written read as zero.
    assign copy_byte = byp_reg ? byp_data_reg : (hit_reg ? rd_q_reg : 8'd0);
    assign rel_addr  = cp_addr_reg - START_PTR_W;

    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        bit_idx_next   = bit_idx_reg;
        bits_left_next = bits_left_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        bytes_next     = bytes_reg;
        olen_next      = olen_reg;
        cp_addr_next   = cp_addr_reg;
        cp_left_next   = cp_left_reg;
        rd_pend_next   = rd_pend_reg;
        byp_next       = byp_reg;
        byp_data_next  = byp_data_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !decomp.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        we             = 1'b0;
        wd             = 8'd0;
        issue          = 1'b0;
        emit           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (comp.valid)
                begin
                    byte_next    = comp.data_byte;
                    bit_idx_next = 3'd7;
                    state_next   = ST_BITS;
                    if (comp.start_req)
                    begin
                        wptr_next  = START_PTR_W;
                        fill_next  = '0;
                        pend_next  = '0;
                        cnt_next   = '0;
                        bytes_next = '0;
                    end
                end
            end

            ST_BITS:
            begin
                if (finished)
                begin
                    // Trailing bits of a finished stream are dropped.
                    state_next = ST_IDLE;
                end
                else if (!(lit && !out_free))
                begin
                    bit_idx_next = bit_idx_reg - 3'd1;
                    if (bit_idx_reg == 3'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    if (lit)
                    begin
                        we        = 1'b1;
                        wd        = nb[7:0];
                        pend_next = '0;
                        cnt_next  = '0;
                    end
                    else if (tok)
                    begin
                        pend_next      = '0;
                        cnt_next       = '0;
                        cp_addr_next   = nb[LENGTH_BITS +: WIN_BITS];
                        cp_left_next   = LEFT_W'(nb[LENGTH_BITS-1:0]) + LEFT_W'(MATCH_MIN);
                        bits_left_next = (bit_idx_reg != 3'd0);
                        state_next     = ST_COPY;
                    end
                    else
                    begin
                        pend_next = nb;
                        cnt_next  = cnt_inc;
                    end
                end
            end

            ST_COPY:
            begin
                if (finished)
                begin
                    // A match that runs past the stream length is cut short.
                    rd_pend_next = 1'b0;
                    cp_left_next = '0;
                    state_next   = bits_left_reg ? ST_BITS : ST_IDLE;
                end
                else
                begin
                    emit = rd_pend_reg && out_free;
                    if (emit)
                    begin
                        we = 1'b1;
                        wd = copy_byte;
                    end
                    issue = (cp_left_reg != '0) && (!rd_pend_reg || emit);
                    if (issue)
                    begin
                        cp_addr_next  = cp_addr_reg + WIN_BITS'(1);
                        cp_left_next  = cp_left_reg - LEFT_W'(1);
                        rd_pend_next  = 1'b1;
                        // The byte written this cycle may be the one read next.
                        byp_next      = we && (wptr_reg == cp_addr_reg);
                        byp_data_next = wd;
                        hit_next      = ({1'b0, rel_addr} < fill_reg);
                    end
                    else if (emit)
                    begin
                        rd_pend_next = 1'b0;
                    end
                    if ((cp_left_reg == '0) && (!rd_pend_reg || emit))
                    begin
                        state_next = bits_left_reg ? ST_BITS : ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (we)
        begin
            wptr_next      = wptr_reg + WIN_BITS'(1);
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + (WIN_BITS + 1)'(1);
            end
            bytes_next     = bytes_reg + 32'd1;
            out_valid_next = 1'b1;
            out_byte_next  = wd;
            out_last_next  = ((bytes_reg + 32'd1) == olen_reg);
        end

        if (cfg_wr_en)
        begin
            olen_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wptr_reg] <= wd;
        end
        if (issue)
        begin
            rd_q_reg <= mem[cp_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bits_left_reg <= 1'b0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            wptr_reg      <= START_PTR_W;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            olen_reg      <= '0;
            cp_left_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            olen_reg      <= olen_next;
            cp_left_reg   <= cp_left_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        bit_idx_reg  <= bit_idx_next;
        cp_addr_reg  <= cp_addr_next;
        byp_reg      <= byp_next;
        byp_data_reg <= byp_data_next;
        hit_reg      <= hit_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule
